@@ rtl/mmet_pkg.sv @@
// Shared types and constants of the masked match edge table.
// Used by every module of the block but mmet_ram; depends on nothing.
package mmet_pkg;

    localparam int unsigned TableEntriesDef = 64;

    localparam int unsigned OpW     = 2;
    localparam int unsigned NodeW   = 32;
    localparam int unsigned FamW    = 5;
    localparam int unsigned PrioW   = 8;
    localparam int unsigned TagW    = 8;
    localparam int unsigned RelW    = 32;
    localparam int unsigned MaskW   = 5;
    localparam int unsigned TimeW   = 48;
    localparam int unsigned OutCntW = 7;

    localparam int unsigned InFieldsW  = 2 * NodeW + FamW + PrioW + TagW + RelW + MaskW + TimeW;
    localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
    localparam int unsigned OutFieldsW = 2 * OutCntW + 1;
    localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

    localparam logic [OpW-1:0] OP_INSERT = 2'd0;
    localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
    localparam logic [OpW-1:0] OP_EXPIRE = 2'd2;

    // Bit positions in the remove mask.
    localparam int unsigned KeyHeadBit = 0;
    localparam int unsigned KeyTailBit = 1;
    localparam int unsigned KeyFamBit  = 2;
    localparam int unsigned KeyPrioBit = 3;
    localparam int unsigned KeyTagBit  = 4;

    localparam logic [TimeW-1:0] TimeMax = '1;

    typedef struct packed {
        logic [NodeW-1:0] head;
        logic [NodeW-1:0] tail;
        logic [FamW-1:0]  family;
        logic [PrioW-1:0] prio;
        logic [TagW-1:0]  tag;
    } t_key;

    typedef struct packed {
        logic             valid;
        t_key             key;
        logic [TimeW-1:0] expiry;
    } t_entry;

    localparam int unsigned EntryW = $bits(t_entry);

    // One operation as the sweep engine sees it; expiry is already absolute.
    typedef struct packed {
        logic [OpW-1:0]   opcode;
        t_key             key;
        logic [MaskW-1:0] mask;
        logic [TimeW-1:0] now;
        logic [TimeW-1:0] expiry;
    } t_req;

    typedef struct packed {
        logic [OutCntW-1:0] removed;
        logic [OutCntW-1:0] occupancy;
        logic               dropped;
    } t_result;

endpackage

@@ rtl/masked_match_edge_table_core.sv @@
// Top level of the masked match edge table: stream ports, expiry arithmetic,
// result register. Depends on mmet_pkg, mmet_ctrl, mmet_ram.
//
// The block keeps TABLE_ENTRIES edge entries in one synchronous RAM and
// answers every accepted item (insert, masked remove or expire sweep) with
// exactly one result item. Each item walks the whole RAM once, one entry per
// cycle through the single read and write port, and an insert then writes
// its new entry in a separate place step. The engine takes the next item only
// in its idle state, so it cannot accept a new item before it is through with
// the last one. The next item is taken once the engine is free, even while
// the previous result still waits on the output. After reset the block clears
// every RAM entry and holds s_tready low meanwhile.
module masked_match_edge_table_core #(
    parameter int unsigned TABLE_ENTRIES = mmet_pkg::TableEntriesDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: head_node, tail_node, edge_family, edge_priority,
    // edge_tag, relative_expiry, match_mask, current_time, zero fill.
    input  logic [mmet_pkg::InDataW-1:0]  s_tdata,
    // Fields from bit 0: opcode.
    input  logic [mmet_pkg::OpW-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: removed_count, occupancy, insert_dropped, zero fill.
    output logic [mmet_pkg::OutDataW-1:0] m_tdata
);
    import mmet_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);

    localparam int unsigned HeadLo = 0;
    localparam int unsigned TailLo = HeadLo + NodeW;
    localparam int unsigned FamLo  = TailLo + NodeW;
    localparam int unsigned PrioLo = FamLo + FamW;
    localparam int unsigned TagLo  = PrioLo + PrioW;
    localparam int unsigned RelLo  = TagLo + TagW;
    localparam int unsigned MaskLo = RelLo + RelW;
    localparam int unsigned TimeLo = MaskLo + MaskW;

    t_req               req;
    logic [RelW-1:0]    rel;
    logic [TimeW:0]     exp_sum;
    logic               start;
    logic               idle;
    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    logic [EntryW-1:0]  ram_wdata;
    logic [EntryW-1:0]  ram_rdata;
    logic               r_m_tvalid;
    logic [OutDataW-1:0] r_m_tdata;

    assign rel            = s_tdata[RelLo +: RelW];
    assign req.opcode     = s_tuser;
    assign req.key.head   = s_tdata[HeadLo +: NodeW];
    assign req.key.tail   = s_tdata[TailLo +: NodeW];
    assign req.key.family = s_tdata[FamLo +: FamW];
    assign req.key.prio   = s_tdata[PrioLo +: PrioW];
    assign req.key.tag    = s_tdata[TagLo +: TagW];
    assign req.mask       = s_tdata[MaskLo +: MaskW];
    assign req.now        = s_tdata[TimeLo +: TimeW];

    // Absolute expiry saturates so that a finite lifetime never reads as zero.
    assign exp_sum = {1'b0, req.now} + {{(TimeW + 1 - RelW){1'b0}}, rel};
    assign req.expiry = (rel == '0)   ? '0 :
                        exp_sum[TimeW] ? TimeMax : exp_sum[TimeW-1:0];

    assign s_tready  = idle;
    assign start     = s_tvalid && idle;
    assign res_ready = !r_m_tvalid || m_tready;

    mmet_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    mmet_ram #(
        .WIDTH (EntryW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_tdata <= {{(OutDataW - OutFieldsW){1'b0}},
                          res.dropped, res.occupancy, res.removed};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

endmodule

@@ rtl/mmet_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependency.
module mmet_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mmet_match.sv @@
// Per-entry decision of the sweep: does the operation delete this entry,
// and may an insert use its slot. Depends on mmet_pkg.
module mmet_match (
    input  mmet_pkg::t_req   i_req,
    input  mmet_pkg::t_entry i_entry,
    output logic             o_kill,
    output logic             o_free
);
    import mmet_pkg::*;

    logic [MaskW-1:0] eq;
    logic [MaskW-1:0] eff_mask;
    logic             key_hit;
    logic             expired;

    always_comb begin
        eq[KeyHeadBit] = (i_entry.key.head == i_req.key.head);
        eq[KeyTailBit] = (i_entry.key.tail == i_req.key.tail);
        eq[KeyFamBit]  = (i_entry.key.family == i_req.key.family);
        eq[KeyPrioBit] = (i_entry.key.prio == i_req.key.prio);
        eq[KeyTagBit]  = (i_entry.key.tag == i_req.key.tag);
    end

    // An insert replaces only exact duplicates, so it compares every key.
    assign eff_mask = (i_req.opcode == OP_INSERT) ? '1 : i_req.mask;
    assign key_hit  = &(eq | ~eff_mask);
    assign expired  = (i_entry.expiry != '0) && (i_entry.expiry < i_req.now);

    always_comb begin
        case (i_req.opcode)
            OP_INSERT, OP_REMOVE: o_kill = i_entry.valid && key_hit;
            OP_EXPIRE:            o_kill = i_entry.valid && expired;
            default:              o_kill = 1'b0;
        endcase
    end

    assign o_free = !i_entry.valid || o_kill;

endmodule

@@ rtl/mmet_ctrl.sv @@
// Sweep engine: clears the entry RAM after reset, then runs each operation as
// one read-modify-write pass over all entries. Depends on mmet_pkg, mmet_match.
module mmet_ctrl #(
    parameter int unsigned TABLE_ENTRIES = mmet_pkg::TableEntriesDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  mmet_pkg::t_req                   i_req,
    output logic                             o_idle,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output mmet_pkg::t_result                o_res,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_ram_raddr,
    input  logic [mmet_pkg::EntryW-1:0]      i_ram_rdata,
    output logic                             o_ram_we,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_ram_waddr,
    output logic [mmet_pkg::EntryW-1:0]      o_ram_wdata
);
    import mmet_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_issue, n_issue;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    t_req          r_req, n_req;
    logic [CW-1:0] r_removed, n_removed;
    logic [CW-1:0] r_count, n_count;
    logic          r_free_found, n_free_found;
    logic [AW-1:0] r_free_addr, n_free_addr;
    logic          r_dropped, n_dropped;

    t_entry        rd_entry;
    t_entry        wr_entry;
    logic          kill;
    logic          free;

    assign rd_entry = i_ram_rdata;

    mmet_match u_match (
        .i_req   (r_req),
        .i_entry (rd_entry),
        .o_kill  (kill),
        .o_free  (free)
    );

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue      = 1'b0;
        n_pend       = 1'b0;
        n_pend_last  = r_pend_last;
        n_pend_addr  = r_pend_addr;
        n_req        = r_req;
        n_removed    = r_removed;
        n_count      = r_count;
        n_free_found = r_free_found;
        n_free_addr  = r_free_addr;
        n_dropped    = r_dropped;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_pend_addr;
        wr_entry       = rd_entry;
        wr_entry.valid = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_addr;
                wr_entry    = '0;
                if (r_addr == LastAddr) begin
                    n_state = ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_req        = i_req;
                    n_state      = ST_SWEEP;
                    n_addr       = '0;
                    n_issue      = 1'b1;
                    n_removed    = '0;
                    n_free_found = 1'b0;
                    n_dropped    = 1'b0;
                end
            end
            ST_SWEEP: begin
                // Reads run one entry ahead of the write-back, so the two
                // never touch the same entry in one cycle.
                if (r_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr;
                    n_pend_last = (r_addr == LastAddr);
                    if (r_addr != LastAddr) begin
                        n_addr  = r_addr + 1'b1;
                        n_issue = 1'b1;
                    end
                end
                if (r_pend) begin
                    if (kill) begin
                        o_ram_we  = 1'b1;
                        n_removed = r_removed + 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                    // The lowest slot that is free once duplicates are gone.
                    if (free && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_addr  = r_pend_addr;
                    end
                    if (r_pend_last) begin
                        n_state = (r_req.opcode == OP_INSERT) ? ST_PLACE : ST_DONE;
                    end
                end
            end
            ST_PLACE: begin
                if (r_free_found) begin
                    o_ram_we        = 1'b1;
                    o_ram_waddr     = r_free_addr;
                    wr_entry.valid  = 1'b1;
                    wr_entry.key    = r_req.key;
                    wr_entry.expiry = r_req.expiry;
                    n_count         = r_count + 1'b1;
                end else begin
                    n_dropped = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_issue      <= 1'b0;
            r_pend       <= 1'b0;
            r_count      <= '0;
            r_free_found <= 1'b0;
            r_dropped    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue      <= n_issue;
            r_pend       <= n_pend;
            r_count      <= n_count;
            r_free_found <= n_free_found;
            r_dropped    <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_pend_addr <= n_pend_addr;
        r_req       <= n_req;
        r_removed   <= n_removed;
        r_free_addr <= n_free_addr;
    end

    assign o_ram_raddr     = r_addr;
    assign o_ram_wdata     = wr_entry;
    assign o_idle          = (r_state == ST_IDLE);
    assign o_res_valid     = (r_state == ST_DONE);
    assign o_res.removed   = OutCntW'(r_removed);
    assign o_res.occupancy = OutCntW'(r_count);
    assign o_res.dropped   = r_dropped;

endmodule

@@ rtl/mmet_checker.sv @@
// Port-level checks of the masked match edge table, bound to the top level.
// Depends on mmet_pkg and masked_match_edge_table_core.
module mmet_checker #(
    parameter int unsigned TABLE_ENTRIES = mmet_pkg::TableEntriesDef
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mmet_pkg::OutDataW-1:0] m_tdata
);
    import mmet_pkg::*;

    localparam logic [OutCntW-1:0] FullCount = OutCntW'(TABLE_ENTRIES);
    localparam bit CountsFit = (TABLE_ENTRIES < (1 << OutCntW));

    logic [OutCntW-1:0] removed;
    logic [OutCntW-1:0] occupancy;
    logic               dropped;

    assign removed   = m_tdata[OutCntW-1:0];
    assign occupancy = m_tdata[2*OutCntW-1:OutCntW];
    assign dropped   = m_tdata[2*OutCntW];

    // A stalled result item keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // A dropped insert means the table was full and nothing was removed.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && dropped |-> removed == '0 && occupancy == FullCount)
        else $error("insert dropped with a free slot");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !CountsFit || occupancy <= FullCount)
        else $error("occupancy exceeds table size");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !CountsFit || removed <= FullCount)
        else $error("removed count exceeds table size");

    // The clearing pass after reset holds off input items.
    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("input accepted during clearing pass");

endmodule

bind masked_match_edge_table_core mmet_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_mmet_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/masked_match_edge_table_core_tb.sv @@
// Self-checking testbench for masked_match_edge_table_core.
// Drives insert, masked remove, expire and undefined-opcode items over the stream ports and checks every
// result item against a table predictor kept inside the bench. Depends on mmet_pkg.
`timescale 1ns / 1ps

module masked_match_edge_table_core_tb;
    import mmet_pkg::*;

    localparam int unsigned TableN    = TableEntriesDef;
    localparam int unsigned RandomOps = 1630;
    localparam int unsigned HoldAt    = 400;
    localparam int unsigned HoldLen   = 1500;
    localparam int unsigned CycleCap  = 1_000_000;

    // Opcode 3 is not defined and must leave the table alone.
    localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
    localparam logic [MaskW-1:0] MaskAll = '1;
    localparam logic [MaskW-1:0] MaskNone = '0;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [NodeW-1:0] head;
        logic [NodeW-1:0] tail;
        logic [FamW-1:0]  fam;
        logic [PrioW-1:0] prio;
        logic [TagW-1:0]  tag;
        logic [RelW-1:0]  rel;
        logic [MaskW-1:0] mask;
        logic [TimeW-1:0] now;
    } t_edge_op;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // Fields from bit 0: head_node, tail_node, edge_family, edge_priority,
    // edge_tag, relative_expiry, match_mask, current_time, zero fill.
    logic [InDataW-1:0]  s_tdata  = '0;
    // Fields from bit 0: opcode.
    logic [OpW-1:0]      s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // Fields from bit 0: removed_count, occupancy, insert_dropped, zero fill.
    logic [OutDataW-1:0] m_tdata;

    masked_match_edge_table_core #(.TABLE_ENTRIES(TableN)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted table contents.
    bit               tbl_valid [TableN];
    bit [NodeW-1:0]   tbl_head  [TableN];
    bit [NodeW-1:0]   tbl_tail  [TableN];
    bit [FamW-1:0]    tbl_fam   [TableN];
    bit [PrioW-1:0]   tbl_prio  [TableN];
    bit [TagW-1:0]    tbl_tag   [TableN];
    bit [TimeW-1:0]   tbl_expiry[TableN];
    int unsigned      tbl_occupancy = 0;

    t_edge_op    pending_ops[$];
    t_result     expected_counts[$];
    t_edge_op    recent_keys[$];
    t_edge_op    cur_op;
    int unsigned ops_total = 0;
    int unsigned ops_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;
    bit          failed = 1'b0;
    bit          rst_done = 1'b0;
    bit          s_fire = 1'b0;
    bit          m_fire = 1'b0;

    function automatic logic [InDataW-1:0] pack_op(t_edge_op r);
        logic [InDataW-1:0] v;
        v = '0;
        v[InFieldsW-1:0] = {r.now, r.mask, r.rel, r.tag, r.prio, r.fam, r.tail, r.head};
        return v;
    endfunction

    // Clears every valid entry that equals the item on the keys the mask selects.
    function automatic int unsigned drop_matches(logic [MaskW-1:0] mask, t_edge_op r);
        int unsigned gone;
        bit hit;
        gone = 0;
        for (int i = 0; i < TableN; i++) begin
            hit = tbl_valid[i];
            if (mask[KeyHeadBit] && tbl_head[i] != r.head) hit = 1'b0;
            if (mask[KeyTailBit] && tbl_tail[i] != r.tail) hit = 1'b0;
            if (mask[KeyFamBit]  && tbl_fam[i]  != r.fam)  hit = 1'b0;
            if (mask[KeyPrioBit] && tbl_prio[i] != r.prio) hit = 1'b0;
            if (mask[KeyTagBit]  && tbl_tag[i]  != r.tag)  hit = 1'b0;
            if (hit) begin
                tbl_valid[i] = 1'b0;
                gone++;
            end
        end
        tbl_occupancy -= gone;
        return gone;
    endfunction

    function automatic t_result predict_table_op(t_edge_op r);
        t_result     res;
        int unsigned gone;
        bit          placed;
        logic [TimeW:0] sum;
        gone = 0;
        placed = 1'b0;
        res.dropped = 1'b0;
        case (r.op)
            OP_INSERT: begin
                gone = drop_matches(MaskAll, r);
                sum = {1'b0, r.now} + (TimeW + 1)'(r.rel);
                for (int i = 0; i < TableN; i++) begin
                    if (!placed && !tbl_valid[i]) begin
                        placed = 1'b1;
                        tbl_valid[i] = 1'b1;
                        tbl_head[i] = r.head;
                        tbl_tail[i] = r.tail;
                        tbl_fam[i] = r.fam;
                        tbl_prio[i] = r.prio;
                        tbl_tag[i] = r.tag;
                        // A lifetime that runs past the end of time sticks at the maximum.
                        if (r.rel == '0) tbl_expiry[i] = '0;
                        else if (sum[TimeW]) tbl_expiry[i] = TimeMax;
                        else tbl_expiry[i] = sum[TimeW-1:0];
                        tbl_occupancy++;
                    end
                end
                res.dropped = !placed;
            end
            OP_REMOVE: begin
                gone = drop_matches(r.mask, r);
            end
            OP_EXPIRE: begin
                for (int i = 0; i < TableN; i++) begin
                    if (tbl_valid[i] && tbl_expiry[i] != '0 && tbl_expiry[i] < r.now) begin
                        tbl_valid[i] = 1'b0;
                        gone++;
                    end
                end
                tbl_occupancy -= gone;
            end
            default: begin
            end
        endcase
        res.removed = gone[OutCntW-1:0];
        res.occupancy = tbl_occupancy[OutCntW-1:0];
        return res;
    endfunction

    function automatic t_edge_op mk_op(logic [OpW-1:0] op, logic [NodeW-1:0] head,
                                       logic [NodeW-1:0] tail, logic [FamW-1:0] fam,
                                       logic [PrioW-1:0] prio, logic [TagW-1:0] tag,
                                       logic [RelW-1:0] rel, logic [MaskW-1:0] mask,
                                       logic [TimeW-1:0] now);
        t_edge_op r;
        r.op = op;
        r.head = head;
        r.tail = tail;
        r.fam = fam;
        r.prio = prio;
        r.tag = tag;
        r.rel = rel;
        r.mask = mask;
        r.now = now;
        return r;
    endfunction

    // Driver: presents the next pending item, with random gaps after each accepted one.
    int unsigned send_gap = 0;
    int unsigned presented = 0;
    bit          send_gappy = 1'b1;

    always @(negedge i_clk) begin
        if (rst_done && (!s_tvalid || s_fire)) begin
            if (s_fire) send_gap = send_gappy ? $urandom_range(0, 8) : 0;
            if (send_gap > 0 || pending_ops.size() == 0) begin
                if (send_gap > 0) send_gap--;
                s_tvalid <= 1'b0;
            end else begin
                cur_op = pending_ops.pop_front();
                s_tdata <= pack_op(cur_op);
                s_tuser <= cur_op.op;
                s_tvalid <= 1'b1;
                presented++;
                if (presented % 64 == 0) send_gappy = 1'($urandom_range(0, 1));
            end
        end
    end

    // Receiver: random stalls after each result item, plus one long hold-off that
    // lets the block back up into its input.
    int unsigned recv_stall = 0;
    int unsigned hold_left = 0;
    int unsigned taken = 0;
    bit          hold_done = 1'b0;
    bit          recv_gappy = 1'b1;

    always @(negedge i_clk) begin
        if (rst_done) begin
            if (m_fire) begin
                taken++;
                if (taken % 50 == 0) recv_gappy = 1'($urandom_range(0, 1));
                recv_stall = recv_gappy ? $urandom_range(0, 8) : 0;
            end
            if (!hold_done && results_seen >= HoldAt) begin
                hold_done = 1'b1;
                hold_left = HoldLen;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor and predictor.
    t_result got;
    t_result want;

    always @(posedge i_clk) begin
        s_fire <= s_tvalid && s_tready;
        m_fire <= m_tvalid && m_tready;
        cycle_count++;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            got.removed = m_tdata[OutCntW-1:0];
            got.occupancy = m_tdata[2*OutCntW-1:OutCntW];
            got.dropped = m_tdata[2*OutCntW];
            if (expected_counts.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                failed = 1'b1;
            end else begin
                want = expected_counts.pop_front();
                if (got.removed !== want.removed) begin
                    $error("removed_count: expected %0d, got %0d", want.removed, got.removed);
                    failed = 1'b1;
                end
                if (got.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                    failed = 1'b1;
                end
                if (got.dropped !== want.dropped) begin
                    $error("insert_dropped: expected %0d, got %0d", want.dropped, got.dropped);
                    failed = 1'b1;
                end
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            expected_counts.push_back(predict_table_op(cur_op));
            ops_accepted++;
        end
        if (cycle_count >= CycleCap) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus and end of run.
    t_edge_op    r;
    bit [TimeW-1:0] time_base;
    bit [NodeW-1:0] head_pool[4];
    bit [NodeW-1:0] tail_pool[4];
    bit          fill_phase;
    int unsigned pick;

    initial begin
        // Directed part: extremes, duplicates, expiry boundary, each mask key, clears.
        pending_ops.push_back(mk_op(OP_UNUSED, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_ops.push_back(mk_op(OP_EXPIRE, '0, '0, '0, '0, '0, '0, '0, 48'd10));
        pending_ops.push_back(mk_op(OP_INSERT, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_ops.push_back(mk_op(OP_INSERT, '1, '1, '1, '1, '1, '1, '1, TimeMax));
        pending_ops.push_back(mk_op(OP_INSERT, '0, '0, '0, '0, '0, '0, '0, 48'd3));
        pending_ops.push_back(mk_op(OP_INSERT, 32'd1, 32'd2, 5'd3, 8'd4, 8'd5, 32'd5, '0,
                                    48'd100));
        pending_ops.push_back(mk_op(OP_EXPIRE, '0, '0, '0, '0, '0, '0, '0, 48'd105));
        pending_ops.push_back(mk_op(OP_EXPIRE, '0, '0, '0, '0, '0, '0, '0, 48'd106));
        pending_ops.push_back(mk_op(OP_EXPIRE, '0, '0, '0, '0, '0, '0, '0, TimeMax));
        pending_ops.push_back(mk_op(OP_INSERT, 32'd10, 32'd20, 5'd1, 8'd2, 8'd3, '0, '0,
                                    48'd200));
        pending_ops.push_back(mk_op(OP_INSERT, 32'd10, 32'd21, 5'd1, 8'd2, 8'd3, '0, '0,
                                    48'd200));
        pending_ops.push_back(mk_op(OP_INSERT, 32'd11, 32'd20, 5'd2, 8'd2, 8'd4, '0, '0,
                                    48'd200));
        pending_ops.push_back(mk_op(OP_REMOVE, 32'd10, '0, '0, '0, '0, '0,
                                    MaskW'(1 << KeyHeadBit), 48'd200));
        pending_ops.push_back(mk_op(OP_REMOVE, '0, 32'd20, '0, '0, '0, '0,
                                    MaskW'(1 << KeyTailBit), 48'd200));
        pending_ops.push_back(mk_op(OP_INSERT, 32'd7, 32'd8, 5'd9, 8'd10, 8'd11, '0, '0,
                                    48'd300));
        pending_ops.push_back(mk_op(OP_INSERT, 32'd7, 32'd8, 5'd9, 8'd10, 8'd12, '0, '0,
                                    48'd300));
        pending_ops.push_back(mk_op(OP_REMOVE, '0, '0, '0, '0, 8'd12, '0,
                                    MaskW'(1 << KeyTagBit), 48'd300));
        pending_ops.push_back(mk_op(OP_REMOVE, '0, '0, 5'd9, 8'd10, '0, '0,
                                    MaskW'((1 << KeyFamBit) | (1 << KeyPrioBit)), 48'd300));
        pending_ops.push_back(mk_op(OP_REMOVE, '1, '1, '1, '1, '1, '0, MaskAll, 48'd300));
        pending_ops.push_back(mk_op(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, TimeMax));
        pending_ops.push_back(mk_op(OP_REMOVE, '1, '1, '1, '1, '1, '1, MaskNone, '1));

        foreach (head_pool[i]) head_pool[i] = $urandom();
        foreach (tail_pool[i]) tail_pool[i] = $urandom();
        time_base = 48'd1000;
        fill_phase = 1'b1;

        // Random part: a small key space so that duplicates and masked hits are common,
        // with fill phases that drive the table to full and churn phases in between.
        for (int n = 0; n < RandomOps; n++) begin
            if (n % 120 == 0) fill_phase = ($urandom_range(0, 2) == 0);
            time_base += TimeW'($urandom_range(0, 20));
            r.now = time_base;
            pick = $urandom_range(0, 99);
            if (pick < 3) r.now = {16'($urandom()), $urandom()};
            else if (pick < 5) r.now = TimeMax - TimeW'($urandom_range(0, 50));

            pick = $urandom_range(0, 99);
            if (fill_phase)
                r.op = pick < 88 ? OP_INSERT : pick < 96 ? OP_REMOVE
                                 : pick < 99 ? OP_EXPIRE : OP_UNUSED;
            else
                r.op = pick < 45 ? OP_INSERT : pick < 75 ? OP_REMOVE
                                 : pick < 95 ? OP_EXPIRE : OP_UNUSED;

            pick = $urandom_range(0, 99);
            if (recent_keys.size() > 0 && (pick < 15 || (r.op == OP_REMOVE && pick < 60))) begin
                t_edge_op old;
                old = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                r.head = old.head;
                r.tail = old.tail;
                r.fam = old.fam;
                r.prio = old.prio;
                r.tag = old.tag;
            end else if ($urandom_range(0, 99) < 85) begin
                r.head = head_pool[$urandom_range(0, 3)];
                r.tail = tail_pool[$urandom_range(0, 3)];
                r.fam = FamW'($urandom_range(0, 3));
                r.prio = PrioW'($urandom_range(0, 3));
                r.tag = TagW'($urandom_range(0, 3));
            end else begin
                r.head = $urandom();
                r.tail = $urandom();
                r.fam = FamW'($urandom());
                r.prio = PrioW'($urandom());
                r.tag = TagW'($urandom());
            end

            pick = $urandom_range(0, 99);
            if (r.op != OP_INSERT) r.rel = $urandom();
            else if (pick < (fill_phase ? 70 : 40)) r.rel = '0;
            else if (pick < 85) r.rel = $urandom_range(1, 200);
            else if (pick < 93) r.rel = $urandom();
            else r.rel = '1;

            if (r.op != OP_REMOVE) r.mask = MaskW'($urandom());
            else if (fill_phase) r.mask = MaskAll;
            else if ($urandom_range(0, 99) < 3) r.mask = MaskNone;
            else r.mask = MaskW'($urandom_range(1, 31));

            if (r.op == OP_INSERT) begin
                recent_keys.push_back(r);
                if (recent_keys.size() > 8) void'(recent_keys.pop_front());
            end
            pending_ops.push_back(r);
        end
        ops_total = pending_ops.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done <= 1'b1;

        while (ops_accepted < ops_total || expected_counts.size() != 0) @(posedge i_clk);
        repeat (2 * TableN) @(posedge i_clk);
        if (!failed && expected_counts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mmet_pkg.sv
rtl/mmet_ram.sv
rtl/mmet_match.sv
rtl/mmet_ctrl.sv
rtl/masked_match_edge_table_core.sv
rtl/mmet_checker.sv
tb/masked_match_edge_table_core_tb.sv
